// File: rtl/core/uabt_pkg.sv
package uabt_pkg;

  localparam int unsigned TableEntriesDefault = 16;
  localparam int unsigned KeyHalfW = 64;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RULE_ALL    = 2'd0,
    RULE_READS  = 2'd1,
    RULE_WRITES = 2'd2
  } rule_e;

  typedef struct packed {
    logic [1:0]          kind;
    logic [KeyHalfW-1:0] key_high;
    logic [KeyHalfW-1:0] key_low;
    logic [1:0]          rule;
  } req_t;

  typedef struct packed {
    logic hit;
    logic blocked_all;
    logic blocked_reads;
    logic blocked_writes;
    logic full_drop;
  } result_t;

endpackage

// File: rtl/core/uabt_cam.sv
module uabt_cam #(
  parameter int unsigned Entries = uabt_pkg::TableEntriesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  uabt_pkg::req_t    req_i,
  output uabt_pkg::result_t res_o
);
  import uabt_pkg::*;

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  logic [KeyHalfW-1:0] key_high_q [Entries];
  logic [KeyHalfW-1:0] key_low_q  [Entries];
  logic [1:0]          rule_q     [Entries];
  logic [Entries-1:0]  valid_q, valid_d;

  logic [Entries-1:0] match;
  logic               hit_any;
  logic [1:0]         hit_rule;
  logic [IdxW-1:0]    free_idx;
  logic               free_any;
  logic               rule_ok;
  logic               do_insert_new;
  logic               do_merge;

  // parallel compare against every stored key
  always_comb begin
    hit_rule = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (key_high_q[i] == req_i.key_high) &&
                 (key_low_q[i] == req_i.key_low);
      // at most one entry matches, so an or of the gated rules selects it
      hit_rule = hit_rule | (match[i] ? rule_q[i] : 2'b00);
    end
  end

  assign hit_any = |match;

  // lowest-numbered free slot
  always_comb begin
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IdxW'(i);
    end
  end

  assign free_any = ~&valid_q;
  assign rule_ok  = (req_i.rule == RULE_ALL) || (req_i.rule == RULE_READS) ||
                    (req_i.rule == RULE_WRITES);

  assign do_insert_new = req_valid_i && (req_i.kind == KIND_INSERT) && rule_ok &&
                         !hit_any && free_any;
  assign do_merge      = req_valid_i && (req_i.kind == KIND_INSERT) && rule_ok && hit_any;

  always_comb begin
    valid_d = valid_q;
    if (req_valid_i && (req_i.kind == KIND_CLEAR)) begin
      valid_d = '0;
    end else if (do_insert_new) begin
      valid_d[free_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Entries; i++) begin
      if (do_insert_new && (free_idx == IdxW'(i))) begin
        key_high_q[i] <= req_i.key_high;
        key_low_q[i]  <= req_i.key_low;
        rule_q[i]     <= req_i.rule;
      end else if (do_merge && match[i] && (rule_q[i] != req_i.rule)) begin
        rule_q[i] <= RULE_ALL;
      end
    end
  end

  always_comb begin
    res_o = '0;
    unique case (req_i.kind)
      KIND_INSERT: begin
        res_o.hit       = hit_any;
        res_o.full_drop = rule_ok && !hit_any && !free_any;
      end
      KIND_LOOKUP: begin
        res_o.hit            = hit_any;
        res_o.blocked_all    = hit_any && (hit_rule == RULE_ALL);
        res_o.blocked_reads  = hit_any && ((hit_rule == RULE_ALL) || (hit_rule == RULE_READS));
        res_o.blocked_writes = hit_any && ((hit_rule == RULE_ALL) ||
                                           (hit_rule == RULE_WRITES));
      end
      default: res_o = '0;
    endcase
  end

endmodule

// File: rtl/core/uuid_access_block_table.sv
// channel   | handshake        | ports
// ----------+------------------+--------------------------------------------------
// command   | start_i, busy_o  | kind_i, key_high_i, key_low_i, rule_i
// result    | done_o strobe    | hit_o, blocked_all_o, blocked_reads_o,
//           |                  | blocked_writes_o, full_drop_o
//
// one command per cycle; busy_o stays low, a command is taken in every cycle
// a command passes the command register, then the parallel key compare and
// table update feed the result register
// reset empties the table at once through the valid bits, no clearing pass
// the receiver cannot stall, each result strobe lasts one cycle
module uuid_access_block_table #(
  parameter int unsigned TableEntries = uabt_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    kind_i,
  input  logic [uabt_pkg::KeyHalfW-1:0] key_high_i,
  input  logic [uabt_pkg::KeyHalfW-1:0] key_low_i,
  input  logic [1:0]                    rule_i,
  output logic                          done_o,
  output logic                          hit_o,
  output logic                          blocked_all_o,
  output logic                          blocked_reads_o,
  output logic                          blocked_writes_o,
  output logic                          full_drop_o
);
  import uabt_pkg::*;

  req_t    req_q;
  logic    req_valid_q;
  result_t res_d, res_q;
  logic    done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= '{kind: kind_i, key_high: key_high_i, key_low: key_low_i, rule: rule_i};
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  uabt_cam #(
    .Entries(TableEntries)
  ) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_q),
    .req_i      (req_q),
    .res_o      (res_d)
  );

  assign done_o           = done_q;
  assign hit_o            = res_q.hit;
  assign blocked_all_o    = res_q.blocked_all;
  assign blocked_reads_o  = res_q.blocked_reads;
  assign blocked_writes_o = res_q.blocked_writes;
  assign full_drop_o      = res_q.full_drop;

endmodule

// File: rtl/core/uabt_checker.sv
module uabt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic hit_o,
  input logic blocked_all_o,
  input logic blocked_reads_o,
  input logic blocked_writes_o,
  input logic full_drop_o
);

  // every accepted command gives its result through the command and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result missing two cycles after command transfer");

  a_flags_need_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (blocked_all_o || blocked_reads_o || blocked_writes_o)) |-> hit_o)
    else $error("blocked flag without hit");

  a_all_implies_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && blocked_all_o) |-> (blocked_reads_o && blocked_writes_o))
    else $error("block all without read and write flags");

  // a drop only happens for an absent key, and never on a lookup
  a_drop_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && full_drop_o) |-> (!hit_o && !blocked_reads_o && !blocked_writes_o))
    else $error("full drop together with hit or blocked flags");

endmodule

bind uuid_access_block_table uabt_checker u_uabt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .done_o          (done_o),
  .hit_o           (hit_o),
  .blocked_all_o   (blocked_all_o),
  .blocked_reads_o (blocked_reads_o),
  .blocked_writes_o(blocked_writes_o),
  .full_drop_o     (full_drop_o)
);
